// ===== hdl/cjkd_pkg.sv =====
// ----------------------------------------------------------------------------
// cjkd_pkg: shared types and constants for the CJK string literal detector
// Item structs for both channels, byte class flags and the CJK range check.
// ----------------------------------------------------------------------------
package cjkd_pkg;

    // input item: one source byte and its end-of-file mark
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    // result item: verdict and sub-flags
    typedef struct packed {
        logic cjk_found;
        logic utf8_valid;
        logic lead_seen;
    } t_out_item;

    // byte class flags worked out by the front end
    typedef struct packed {
        logic is_slash;
        logic is_star;
        logic is_squote;
        logic is_dquote;
        logic is_bslash;
        logic is_newline;
        logic is_e4e9;
    } t_byte_class;

    // entry of the queue between front and back
    typedef struct packed {
        logic [7:0]  text_byte;
        logic        last_byte;
        t_byte_class cls;
    } t_queue_item;

    // characters the lexer cares about
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // window of lead bytes that is tracked on its own
    localparam logic [7:0] LEAD_LO = 8'hE4;
    localparam logic [7:0] LEAD_HI = 8'hE9;

    // code point ranges counted as CJK
    localparam logic [15:0] CJK_UNI_LO  = 16'h4E00;
    localparam logic [15:0] CJK_UNI_HI  = 16'h9FFF;
    localparam logic [15:0] CJK_EXTA_LO = 16'h3400;
    localparam logic [15:0] CJK_EXTA_HI = 16'h4DBF;
    localparam logic [15:0] CJK_COMP_LO = 16'hF900;
    localparam logic [15:0] CJK_COMP_HI = 16'hFAFF;
    localparam logic [15:0] CJK_FULL_LO = 16'hFF00;
    localparam logic [15:0] CJK_FULL_HI = 16'hFFEF;
    localparam logic [15:0] CJK_PUNC_LO = 16'h3000;
    localparam logic [15:0] CJK_PUNC_HI = 16'h303F;
    localparam logic [15:0] CJK_FORM_LO = 16'hFE30;
    localparam logic [15:0] CJK_FORM_HI = 16'hFE4F;

    // true when a 21-bit code point lies in one of the CJK ranges
    function automatic logic in_cjk(input logic [20:0] cp);
        logic [15:0] lo16;
        logic        bmp;
        lo16 = cp[15:0];
        bmp  = (cp[20:16] == 5'd0);
        return bmp && (
               (lo16 >= CJK_UNI_LO  && lo16 <= CJK_UNI_HI)
            || (lo16 >= CJK_EXTA_LO && lo16 <= CJK_EXTA_HI)
            || (lo16 >= CJK_COMP_LO && lo16 <= CJK_COMP_HI)
            || (lo16 >= CJK_FULL_LO && lo16 <= CJK_FULL_HI)
            || (lo16 >= CJK_PUNC_LO && lo16 <= CJK_PUNC_HI)
            || (lo16 >= CJK_FORM_LO && lo16 <= CJK_FORM_HI));
    endfunction

endpackage

// ===== hdl/cjkd_front.sv =====
// ----------------------------------------------------------------------------
// cjkd_front: input side of the detector
// Takes source bytes, tags them with class flags and writes the queue.
// ----------------------------------------------------------------------------
module cjkd_front (
    input  cjkd_pkg::t_in_item    i_item,
    input  logic                  i_push,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_q_wr,
    output cjkd_pkg::t_queue_item o_q_item
);
    import cjkd_pkg::*;

    t_byte_class w_cls;

    // byte classification
    always_comb begin
        w_cls.is_slash   = (i_item.text_byte == CH_SLASH);
        w_cls.is_star    = (i_item.text_byte == CH_STAR);
        w_cls.is_squote  = (i_item.text_byte == CH_SQUOTE);
        w_cls.is_dquote  = (i_item.text_byte == CH_DQUOTE);
        w_cls.is_bslash  = (i_item.text_byte == CH_BSLASH);
        w_cls.is_newline = (i_item.text_byte == CH_NEWLINE);
        w_cls.is_e4e9    = (i_item.text_byte >= LEAD_LO) && (i_item.text_byte <= LEAD_HI);
    end

    // transfer into the queue
    assign o_full             = i_q_full;
    assign o_q_wr             = i_push && !i_q_full;
    assign o_q_item.text_byte = i_item.text_byte;
    assign o_q_item.last_byte = i_item.last_byte;
    assign o_q_item.cls       = w_cls;

endmodule

// ===== hdl/cjkd_queue.sv =====
// ----------------------------------------------------------------------------
// cjkd_queue: short queue between front and back
// Circular buffer of classified bytes with a fill count.
// ----------------------------------------------------------------------------
module cjkd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  cjkd_pkg::t_queue_item i_wr_item,
    input  logic                  i_rd,
    output logic                  o_full,
    output logic                  o_valid,
    output cjkd_pkg::t_queue_item o_rd_item
);
    import cjkd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_queue_item   r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_valid   = (r_cnt != '0);
    assign o_rd_item = r_mem[r_rd_ptr];
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_rd && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // fill count never passes the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT) else $error("queue count over depth");

    // a write into a full queue with no read leaves the count at full
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |=> o_full) else $error("full queue lost an entry");

    // a read with no write from a single entry drains the queue
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(1) && i_rd && !i_wr) |=> !o_valid)
        else $error("queue did not drain");
`endif

endmodule

// ===== hdl/cjkd_back.sv =====
// ----------------------------------------------------------------------------
// cjkd_back: lexer, UTF-8 decoder and validator
// Runs one queued byte a cycle while the output queue has room, and holds verdicts in a two-entry output queue.
// ----------------------------------------------------------------------------
module cjkd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  cjkd_pkg::t_queue_item i_q_item,
    output logic                  o_q_rd,
    input  logic                  i_pop,
    output logic                  o_empty,
    output cjkd_pkg::t_out_item   o_out_item
);
    import cjkd_pkg::*;

    typedef enum logic [2:0] {
        LM_CODE,
        LM_LINE,
        LM_BLOCK,
        LM_CHAR,
        LM_STR
    } t_lex_mode;

    typedef enum logic [2:0] {
        V_LEAD,
        V_C1,
        V_C2,
        V_C3,
        V_E0,
        V_ED,
        V_F0,
        V_F4
    } t_vstate;

    // lexer and validator state
    t_lex_mode   r_lex_mode,  n_lex_mode;
    logic        r_escape,    n_escape;
    logic        r_slash,     n_slash;
    logic        r_star,      n_star;
    logic [20:0] r_acc,       n_acc;
    logic [1:0]  r_cont,      n_cont;
    logic        r_cjk,       n_cjk;
    logic        r_lead,      n_lead;
    t_vstate     r_vstate,    n_vstate;
    logic        r_err,       n_err;

    // output queue
    t_out_item   r_out0, r_out1;
    logic [1:0]  r_out_cnt;

    logic        w_step;
    logic        w_result;
    logic        w_pop;
    t_out_item   w_res;
    logic [7:0]  w_b;
    t_byte_class w_c;
    logic [7:0]  w_lo;
    logic [7:0]  w_hi;
    t_vstate     w_vnext;
    logic        w_vcont;
    logic        w_valid;

    assign w_b     = i_q_item.text_byte;
    assign w_c     = i_q_item.cls;
    assign w_step  = i_q_valid && (r_out_cnt != 2'd2);
    assign o_q_rd  = w_step;
    assign w_pop   = i_pop && (r_out_cnt != 2'd0);
    assign o_empty = (r_out_cnt == 2'd0);
    assign o_out_item = r_out0;

    // next state of validator and lexer
    always_comb begin
        n_lex_mode = r_lex_mode;
        n_escape   = r_escape;
        n_slash    = r_slash;
        n_star     = r_star;
        n_acc      = r_acc;
        n_cont     = r_cont;
        n_cjk      = r_cjk;
        n_lead     = r_lead || w_c.is_e4e9;
        n_vstate   = r_vstate;
        n_err      = r_err;
        w_lo       = 8'h80;
        w_hi       = 8'hBF;
        w_vnext    = V_LEAD;
        w_vcont    = 1'b0;

        // well-formedness check
        if (!r_err) begin
            case (r_vstate)
                V_LEAD: begin
                    case (w_b) inside
                        [8'h00:8'h7F]: ;
                        [8'hC2:8'hDF]: n_vstate = V_C1;
                        8'hE0:         n_vstate = V_E0;
                        8'hED:         n_vstate = V_ED;
                        [8'hE1:8'hEF]: n_vstate = V_C2;
                        8'hF0:         n_vstate = V_F0;
                        [8'hF1:8'hF3]: n_vstate = V_C3;
                        8'hF4:         n_vstate = V_F4;
                        default:       n_err    = 1'b1;
                    endcase
                end
                V_C1: begin w_vcont = 1'b1; w_vnext = V_LEAD; end
                V_C2: begin w_vcont = 1'b1; w_vnext = V_C1;   end
                V_C3: begin w_vcont = 1'b1; w_vnext = V_C2;   end
                V_E0: begin w_vcont = 1'b1; w_lo = 8'hA0; w_vnext = V_C1; end
                V_ED: begin w_vcont = 1'b1; w_hi = 8'h9F; w_vnext = V_C1; end
                V_F0: begin w_vcont = 1'b1; w_lo = 8'h90; w_vnext = V_C2; end
                V_F4: begin w_vcont = 1'b1; w_hi = 8'h8F; w_vnext = V_C2; end
                default: n_err = 1'b1;
            endcase
            if (w_vcont) begin
                if (w_b < w_lo || w_b > w_hi) begin
                    n_err = 1'b1;
                end else begin
                    n_vstate = w_vnext;
                end
            end
        end

        // lexer context
        case (r_lex_mode)
            LM_LINE: begin
                if (w_c.is_newline) n_lex_mode = LM_CODE;
            end
            LM_BLOCK: begin
                if (r_star && w_c.is_slash) begin
                    n_lex_mode = LM_CODE;
                    n_star     = 1'b0;
                end else begin
                    n_star = w_c.is_star;
                end
            end
            LM_CHAR: begin
                if (r_escape) begin
                    n_escape = 1'b0;
                end else if (w_c.is_bslash) begin
                    n_escape = 1'b1;
                end else if (w_c.is_squote) begin
                    n_lex_mode = LM_CODE;
                end
            end
            LM_STR: begin
                if (r_cont != 2'd0) begin
                    n_acc  = {r_acc[14:0], w_b[5:0]};
                    n_cont = r_cont - 2'd1;
                    if (r_cont == 2'd1 && in_cjk(n_acc)) n_cjk = 1'b1;
                end else if (r_escape) begin
                    n_escape = 1'b0;
                end else if (w_c.is_bslash) begin
                    n_escape = 1'b1;
                end else if (w_c.is_dquote) begin
                    n_lex_mode = LM_CODE;
                end else if (w_b[7] && !r_cjk) begin
                    // lead byte starts a sequence
                    if (w_b[7:5] == 3'b110) begin
                        n_acc  = {16'd0, w_b[4:0]};
                        n_cont = 2'd1;
                    end else if (w_b[7:4] == 4'b1110) begin
                        n_acc  = {17'd0, w_b[3:0]};
                        n_cont = 2'd2;
                    end else if (w_b[7:3] == 5'b11110) begin
                        n_acc  = {18'd0, w_b[2:0]};
                        n_cont = 2'd3;
                    end
                end
            end
            default: begin
                // code, with a held slash deciding on comments
                n_lex_mode = LM_CODE;
                if (r_slash && w_c.is_slash) begin
                    n_slash    = 1'b0;
                    n_lex_mode = LM_LINE;
                end else if (r_slash && w_c.is_star) begin
                    n_slash    = 1'b0;
                    n_lex_mode = LM_BLOCK;
                    n_star     = 1'b0;
                end else begin
                    n_slash = w_c.is_slash;
                    if (w_c.is_squote) begin
                        n_lex_mode = LM_CHAR;
                        n_escape   = 1'b0;
                    end else if (w_c.is_dquote) begin
                        n_lex_mode = LM_STR;
                        n_escape   = 1'b0;
                        n_cont     = 2'd0;
                    end
                end
            end
        endcase

        // verdict on the last byte
        w_valid          = !n_err && (n_vstate == V_LEAD);
        w_res.utf8_valid = w_valid;
        w_res.lead_seen  = n_lead;
        w_res.cjk_found  = w_valid && n_lead && n_cjk;
        w_result         = w_step && i_q_item.last_byte;
    end

    // context registers, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_result) begin
            r_lex_mode <= LM_CODE;
            r_escape   <= 1'b0;
            r_slash    <= 1'b0;
            r_star     <= 1'b0;
            r_acc      <= '0;
            r_cont     <= '0;
            r_cjk      <= 1'b0;
            r_lead     <= 1'b0;
            r_vstate   <= V_LEAD;
            r_err      <= 1'b0;
        end else if (w_step) begin
            r_lex_mode <= n_lex_mode;
            r_escape   <= n_escape;
            r_slash    <= n_slash;
            r_star     <= n_star;
            r_acc      <= n_acc;
            r_cont     <= n_cont;
            r_cjk      <= n_cjk;
            r_lead     <= n_lead;
            r_vstate   <= n_vstate;
            r_err      <= n_err;
        end
    end

    // output queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (w_result && !w_pop) begin
            r_out_cnt <= r_out_cnt + 2'd1;
        end else if (w_pop && !w_result) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    // output queue slots
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (w_result && r_out_cnt == 2'd1) begin
                r_out0 <= w_res;
            end else begin
                r_out0 <= r_out1;
            end
            if (w_result) r_out1 <= w_res;
        end else if (w_result) begin
            if (r_out_cnt == 2'd0) begin
                r_out0 <= w_res;
            end else begin
                r_out1 <= w_res;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // output queue holds at most two verdicts
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3) else $error("output queue overflow");

    // after a verdict the context is back at its start
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result |=> (r_lex_mode == LM_CODE && !r_err && r_vstate == V_LEAD && !r_cjk))
        else $error("context not cleared after last byte");

    // a found verdict implies the other two flags
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out_item.cjk_found) |-> (o_out_item.utf8_valid && o_out_item.lead_seen))
        else $error("inconsistent verdict");

    // decoding only goes on inside string literals
    a_cont_str: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cont != 2'd0) |-> (r_lex_mode == LM_STR))
        else $error("pending continuation outside a string");
`endif

endmodule

// ===== hdl/cjk_in_c_string_literal_detector_core.sv =====
// Result path: a last byte passes through the front/back queue, and its verdict is registered in the output queue.
// Throughput: one byte per cycle; the back end retires one queued byte each cycle unless two verdicts wait unpopped.
// Input stalls only when the front/back queue (QUEUE_DEPTH entries) is full,
// which happens when two verdicts wait unpopped in the output queue.
// Reset: synchronous active low; clears lexer, validator, queue pointers and counts.
// ----------------------------------------------------------------------------
// cjk_in_c_string_literal_detector_core: CJK-in-string-literal detector
// Front end classifies source bytes, back end lexes, decodes and validates.
// ----------------------------------------------------------------------------
module cjk_in_c_string_literal_detector_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cjkd_pkg::t_in_item  i_in_item,
    input  logic                push,
    output logic                full,
    output cjkd_pkg::t_out_item o_out_item,
    output logic                empty,
    input  logic                pop
);
    import cjkd_pkg::*;

    logic        w_q_wr;
    logic        w_q_full;
    logic        w_q_valid;
    logic        w_q_rd;
    t_queue_item w_wr_item;
    t_queue_item w_rd_item;

    // classification and input transfer
    cjkd_front u_front (
        .i_item   (i_in_item),
        .i_push   (push),
        .i_q_full (w_q_full),
        .o_full   (full),
        .o_q_wr   (w_q_wr),
        .o_q_item (w_wr_item)
    );

    // decoupling queue
    cjkd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_item (w_wr_item),
        .i_rd      (w_q_rd),
        .o_full    (w_q_full),
        .o_valid   (w_q_valid),
        .o_rd_item (w_rd_item)
    );

    // lexer, decoder and verdict
    cjkd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_rd_item),
        .o_q_rd     (w_q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_item (o_out_item)
    );

endmodule

// ===== test/cjk_in_c_string_literal_detector_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjk_in_c_string_literal_detector_core_tb: self-checking bench for the detector
// Streams small C source files byte by byte, predicts each end-of-file verdict
// with a cycle-free software copy of the lexer and validator, and compares every
// popped verdict field by field. Both queue sides idle in random bursts.
// ----------------------------------------------------------------------------
module cjk_in_c_string_literal_detector_core_tb;
    import cjkd_pkg::*;

    localparam int TOTAL_ITEMS  = 825;
    localparam int QUIET_ITEMS  = 100;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    // cjk ranges as (low, high) pairs, in the same order on both tables
    localparam logic [15:0] RANGE_LO [6] = '{CJK_UNI_LO, CJK_EXTA_LO, CJK_COMP_LO,
                                             CJK_FULL_LO, CJK_PUNC_LO, CJK_FORM_LO};
    localparam logic [15:0] RANGE_HI [6] = '{CJK_UNI_HI, CJK_EXTA_HI, CJK_COMP_HI,
                                             CJK_FULL_HI, CJK_PUNC_HI, CJK_FORM_HI};

    typedef enum logic [2:0] {
        LEX_CODE, LEX_LINE, LEX_BLOCK, LEX_CHAR, LEX_STR
    } t_lex_mode;

    typedef enum logic [3:0] {
        VAL_LEAD, VAL_C1, VAL_C2, VAL_C3, VAL_E0, VAL_ED, VAL_F0, VAL_F4
    } t_val_state;

    // lexer and utf-8 tracker mirror, plus the verdicts still owed by the block
    class t_verdict_scoreboard;
        t_lex_mode   lex_mode;
        t_val_state  val_state;
        bit          esc_hold;
        bit          slash_hold;
        bit          star_hold;
        logic [20:0] point_acc;
        int unsigned cont_left;
        bit          cjk_hit;
        bit          lead_hit;
        bit          utf8_err;
        t_out_item   pending_verdicts[$];
        int          errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            lex_mode   = LEX_CODE;
            val_state  = VAL_LEAD;
            esc_hold   = 1'b0;
            slash_hold = 1'b0;
            star_hold  = 1'b0;
            point_acc  = '0;
            cont_left  = 0;
            cjk_hit    = 1'b0;
            lead_hit   = 1'b0;
            utf8_err   = 1'b0;
        endfunction

        // advance the mirror by one accepted byte
        function void note_byte(t_in_item item);
            logic [7:0] b;
            logic [7:0] lo;
            logic [7:0] hi;
            t_val_state nxt;
            bit         range_check;
            bit         opened;
            t_out_item  want;
            b = item.text_byte;

            if (b >= LEAD_LO && b <= LEAD_HI) lead_hit = 1'b1;

            // well-formedness, sticky on the first error
            if (!utf8_err) begin
                lo = 8'h80;
                hi = 8'hBF;
                nxt = VAL_LEAD;
                range_check = 1'b1;
                case (val_state)
                    VAL_LEAD: begin
                        range_check = 1'b0;
                        if (b >= 8'h80) begin
                            if (b >= 8'hC2 && b <= 8'hDF) val_state = VAL_C1;
                            else if (b == 8'hE0) val_state = VAL_E0;
                            else if (b == 8'hED) val_state = VAL_ED;
                            else if (b >= 8'hE1 && b <= 8'hEF) val_state = VAL_C2;
                            else if (b == 8'hF0) val_state = VAL_F0;
                            else if (b >= 8'hF1 && b <= 8'hF3) val_state = VAL_C3;
                            else if (b == 8'hF4) val_state = VAL_F4;
                            else utf8_err = 1'b1;
                        end
                    end
                    VAL_C1: nxt = VAL_LEAD;
                    VAL_C2: nxt = VAL_C1;
                    VAL_C3: nxt = VAL_C2;
                    VAL_E0: begin lo = 8'hA0; nxt = VAL_C1; end
                    VAL_ED: begin hi = 8'h9F; nxt = VAL_C1; end
                    VAL_F0: begin lo = 8'h90; nxt = VAL_C2; end
                    VAL_F4: begin hi = 8'h8F; nxt = VAL_C2; end
                    default: begin
                        range_check = 1'b0;
                        utf8_err = 1'b1;
                    end
                endcase
                if (range_check) begin
                    if (b < lo || b > hi) utf8_err = 1'b1;
                    else val_state = nxt;
                end
            end

            // lexer context
            case (lex_mode)
                LEX_LINE: if (b == CH_NEWLINE) lex_mode = LEX_CODE;
                LEX_BLOCK: begin
                    if (star_hold && b == CH_SLASH) begin
                        lex_mode = LEX_CODE;
                        star_hold = 1'b0;
                    end else begin
                        star_hold = (b == CH_STAR);
                    end
                end
                LEX_CHAR: begin
                    if (esc_hold) esc_hold = 1'b0;
                    else if (b == CH_BSLASH) esc_hold = 1'b1;
                    else if (b == CH_SQUOTE) lex_mode = LEX_CODE;
                end
                LEX_STR: begin
                    if (cont_left > 0) begin
                        // continuation slot takes any byte value
                        point_acc = {point_acc[14:0], b[5:0]};
                        cont_left--;
                        if (cont_left == 0 && (
                               (point_acc >= CJK_UNI_LO  && point_acc <= CJK_UNI_HI)
                            || (point_acc >= CJK_EXTA_LO && point_acc <= CJK_EXTA_HI)
                            || (point_acc >= CJK_COMP_LO && point_acc <= CJK_COMP_HI)
                            || (point_acc >= CJK_FULL_LO && point_acc <= CJK_FULL_HI)
                            || (point_acc >= CJK_PUNC_LO && point_acc <= CJK_PUNC_HI)
                            || (point_acc >= CJK_FORM_LO && point_acc <= CJK_FORM_HI)))
                            cjk_hit = 1'b1;
                    end else if (esc_hold) begin
                        esc_hold = 1'b0;
                    end else if (b == CH_BSLASH) begin
                        esc_hold = 1'b1;
                    end else if (b == CH_DQUOTE) begin
                        lex_mode = LEX_CODE;
                    end else if (b[7] && !cjk_hit) begin
                        if (b[7:5] == 3'b110) begin
                            point_acc = {16'd0, b[4:0]};
                            cont_left = 1;
                        end else if (b[7:4] == 4'b1110) begin
                            point_acc = {17'd0, b[3:0]};
                            cont_left = 2;
                        end else if (b[7:3] == 5'b11110) begin
                            point_acc = {18'd0, b[2:0]};
                            cont_left = 3;
                        end
                    end
                end
                default: begin
                    // code: a held slash is resolved by this byte
                    lex_mode = LEX_CODE;
                    opened = 1'b0;
                    if (slash_hold) begin
                        slash_hold = 1'b0;
                        if (b == CH_SLASH) begin
                            lex_mode = LEX_LINE;
                            opened = 1'b1;
                        end else if (b == CH_STAR) begin
                            lex_mode = LEX_BLOCK;
                            star_hold = 1'b0;
                            opened = 1'b1;
                        end
                    end
                    if (!opened) begin
                        if (b == CH_SLASH) begin
                            slash_hold = 1'b1;
                        end else if (b == CH_SQUOTE) begin
                            lex_mode = LEX_CHAR;
                            esc_hold = 1'b0;
                        end else if (b == CH_DQUOTE) begin
                            lex_mode = LEX_STR;
                            esc_hold = 1'b0;
                            cont_left = 0;
                        end
                    end
                end
            endcase

            // end of file: verdict owed, state starts over
            if (item.last_byte) begin
                want.utf8_valid = !utf8_err && val_state == VAL_LEAD;
                want.lead_seen  = lead_hit;
                want.cjk_found  = want.utf8_valid && lead_hit && cjk_hit;
                pending_verdicts.push_back(want);
                clear_state();
            end
        endfunction

        // compare a popped verdict with the oldest one owed
        function void check_verdict(t_out_item got);
            t_out_item want;
            if (pending_verdicts.size() == 0) begin
                $error("verdict %b popped with none outstanding", got);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.cjk_found !== want.cjk_found) begin
                $error("cjk_found: expected %0b, actual %0b", want.cjk_found, got.cjk_found);
                errors++;
            end
            if (got.utf8_valid !== want.utf8_valid) begin
                $error("utf8_valid: expected %0b, actual %0b", want.utf8_valid, got.utf8_valid);
                errors++;
            end
            if (got.lead_seen !== want.lead_seen) begin
                $error("lead_seen: expected %0b, actual %0b", want.lead_seen, got.lead_seen);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    t_in_item  i_in_item = '0;
    logic      push = 1'b0;
    logic      full;
    t_out_item o_out_item;
    logic      empty;
    logic      pop = 1'b0;

    // transfers seen at the falling edge, taken at the next rising edge
    logic      in_fire = 1'b0;
    logic      out_fire = 1'b0;
    t_in_item  in_snap;
    t_out_item out_snap;

    logic [7:0] file_text[$];
    string      code_chars = "abz09 ;=+(){}_\t";
    int         sent_items = 0;
    bit         quiet = 1'b0;
    int         send_gap_pct = 0;
    int         recv_gap_pct = 0;
    int         pop_gap = 0;
    int         stall_cycles = 0;

    t_verdict_scoreboard board = new();

    cjk_in_c_string_literal_detector_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .push       (push),
        .full       (full),
        .o_out_item (o_out_item),
        .empty      (empty),
        .pop        (pop)
    );

    always #10 i_clk = ~i_clk;

    // handshake sampling at the falling edge, after every drive has settled
    always @(negedge i_clk) begin
        in_fire  = i_rst_n && push && !full;
        out_fire = i_rst_n && pop && !empty;
        in_snap  = i_in_item;
        out_snap = o_out_item;
    end

    // scoreboard updates and stall watchdog
    always @(posedge i_clk) begin
        if (in_fire) board.note_byte(in_snap);
        if (out_fire) board.check_verdict(out_snap);
        if (in_fire || out_fire || !i_rst_n) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: pop with random stall bursts
    always @(posedge i_clk) begin
        if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < recv_gap_pct) begin
            pop_gap = $urandom_range(0, 9);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // one plain code character
    function automatic void put_ascii();
        file_text.push_back(code_chars[$urandom_range(0, code_chars.len() - 1)]);
    endfunction

    // one utf-8 character, inside a cjk range or around it
    function automatic void put_char_utf8(bit want_cjk);
        logic [20:0] cp;
        int          r;
        r = $urandom_range(0, 5);
        if (want_cjk) begin
            case ($urandom_range(0, 2))
                0: cp = {5'd0, RANGE_LO[r]};
                1: cp = {5'd0, RANGE_HI[r]};
                default: cp = 21'($urandom_range(RANGE_LO[r], RANGE_HI[r]));
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0: cp = 21'($urandom_range('h80, 'h7FF));
                1: cp = 21'($urandom_range('h800, 'hFFFF));
                2: cp = {5'd0, RANGE_LO[r]} - 21'd1;
                3: cp = {5'd0, RANGE_HI[r]} + 21'd1;
                // outside the basic plane, low half inside a cjk range
                4: cp = {5'($urandom_range(1, 16)), RANGE_LO[r]};
                default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
        end
        if (cp < 21'h80) begin
            file_text.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            file_text.push_back({3'b110, cp[10:6]});
            file_text.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            file_text.push_back({4'b1110, cp[15:12]});
            file_text.push_back({2'b10, cp[11:6]});
            file_text.push_back({2'b10, cp[5:0]});
        end else begin
            file_text.push_back({5'b11110, cp[20:18]});
            file_text.push_back({2'b10, cp[17:12]});
            file_text.push_back({2'b10, cp[11:6]});
            file_text.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // push one file, last byte marked, with random gaps before bytes
    task automatic send_file();
        t_in_item item;
        for (int k = 0; k < file_text.size(); k++) begin
            if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            item.text_byte = file_text[k];
            item.last_byte = (k == file_text.size() - 1);
            i_in_item <= item;
            push <= 1'b1;
            do @(posedge i_clk); while (!in_fire);
            sent_items++;
        end
        file_text.delete();
    endtask

    initial begin
        int n_tok;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cjk ideograph inside a string literal
        file_text = '{CH_DQUOTE, 8'hE4, 8'hB8, 8'hAD, CH_DQUOTE};
        send_file();
        // single-byte files at both byte extremes
        file_text = '{8'h00};
        send_file();
        file_text = '{8'hFF};
        send_file();
        // block comment whose opening slash-star does not close it
        file_text = '{CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_SLASH, CH_NEWLINE};
        send_file();
        // escaped quote in a string, then a multibyte sequence cut by the end
        file_text = '{CH_DQUOTE, CH_BSLASH, CH_DQUOTE, 8'hE9, 8'hA0};
        send_file();
        // escaped char literal, line comment, stray continuation byte
        file_text = '{CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE, CH_SLASH, CH_SLASH, 8'h80};
        send_file();

        // random files, mostly well-formed source with random content
        while (sent_items < TOTAL_ITEMS) begin
            quiet = (sent_items >= TOTAL_ITEMS - QUIET_ITEMS);
            case ($urandom_range(0, 2))
                0: send_gap_pct = 0;
                1: send_gap_pct = 5;
                default: send_gap_pct = 25;
            endcase
            case ($urandom_range(0, 2))
                0: recv_gap_pct = 0;
                1: recv_gap_pct = 5;
                default: recv_gap_pct = 25;
            endcase

            if ($urandom_range(0, 99) < 75) begin
                // byte order mark now and then
                if ($urandom_range(0, 9) == 0) file_text = '{8'hEF, 8'hBB, 8'hBF};
                n_tok = $urandom_range(1, 5);
                repeat (n_tok) begin
                    case ($urandom_range(0, 5))
                        0: repeat ($urandom_range(1, 3)) put_ascii();
                        1: begin
                            // string literal
                            file_text.push_back(CH_DQUOTE);
                            repeat ($urandom_range(0, 4)) begin
                                case ($urandom_range(0, 4))
                                    0: put_ascii();
                                    1: begin
                                        file_text.push_back(CH_BSLASH);
                                        case ($urandom_range(0, 2))
                                            0: file_text.push_back(CH_DQUOTE);
                                            1: file_text.push_back(CH_BSLASH);
                                            default: file_text.push_back("n");
                                        endcase
                                    end
                                    2, 3: put_char_utf8(1'b1);
                                    default: put_char_utf8(1'b0);
                                endcase
                            end
                            file_text.push_back(CH_DQUOTE);
                        end
                        2: begin
                            // char literal
                            file_text.push_back(CH_SQUOTE);
                            case ($urandom_range(0, 2))
                                0: put_ascii();
                                1: begin
                                    file_text.push_back(CH_BSLASH);
                                    file_text.push_back(CH_SQUOTE);
                                end
                                default: put_char_utf8(1'($urandom_range(0, 1)));
                            endcase
                            file_text.push_back(CH_SQUOTE);
                        end
                        3: begin
                            // line comment
                            file_text.push_back(CH_SLASH);
                            file_text.push_back(CH_SLASH);
                            repeat ($urandom_range(0, 3)) begin
                                case ($urandom_range(0, 2))
                                    0: put_ascii();
                                    1: file_text.push_back(CH_DQUOTE);
                                    default: put_char_utf8(1'($urandom_range(0, 1)));
                                endcase
                            end
                            file_text.push_back(CH_NEWLINE);
                        end
                        4: begin
                            // block comment
                            file_text.push_back(CH_SLASH);
                            file_text.push_back(CH_STAR);
                            repeat ($urandom_range(0, 3)) begin
                                case ($urandom_range(0, 3))
                                    0: put_ascii();
                                    1: file_text.push_back(CH_STAR);
                                    2: file_text.push_back(CH_DQUOTE);
                                    default: put_char_utf8(1'($urandom_range(0, 1)));
                                endcase
                            end
                            file_text.push_back(CH_STAR);
                            file_text.push_back(CH_SLASH);
                        end
                        default: file_text.push_back(CH_NEWLINE);
                    endcase
                end
            end else begin
                // noise: raw bytes and malformed sequences, often inside a string
                if ($urandom_range(0, 1)) file_text.push_back(CH_DQUOTE);
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 2))
                        0: file_text.push_back(8'($urandom_range(0, 255)));
                        1: begin
                            file_text.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                            repeat ($urandom_range(0, 3))
                                file_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        default: put_char_utf8(1'($urandom_range(0, 1)));
                    endcase
                end
            end

            // sometimes the file ends one byte early
            if ($urandom_range(0, 9) == 0 && file_text.size() > 1) void'(file_text.pop_back());
            send_file();
        end
        push <= 1'b0;

        // drain the verdicts still owed, then let the pipe settle
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
